[rtl/waypoint_guidance_controller_macros.svh]
// assertion macros for the waypoint guidance controller
`ifndef WAYPOINT_GUIDANCE_CONTROLLER_MACROS_SVH
`define WAYPOINT_GUIDANCE_CONTROLLER_MACROS_SVH

// checked only outside reset
`define WGC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define WGC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/wgc_pkg.sv]
package wgc_pkg;

  localparam int ROUTE_DEPTH_DEF = 256;
  localparam int GOAL_DEPTH_DEF  = 16;

  localparam int CW         = 40;
  localparam int ZW         = 20;
  localparam int CORD_STEPS = 16;
  localparam int IT_W       = $clog2(CORD_STEPS);
  localparam int MBW        = 18;
  localparam int PW         = CW + MBW;
  localparam int QW         = 34;

  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [MBW-1:0] KINV_Q16   = 18'sd39797;
  localparam logic signed [17:0] PI_Q13        = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13    = 18'sd51472;

  localparam logic [14:0] CRUISE_RST = 15'd614;
  localparam logic [15:0] HGAIN_RST  = 16'd1843;
  localparam logic [15:0] CGAIN_RST  = 16'd205;
  localparam logic [14:0] RLIM_RST   = 15'd1024;
  localparam logic [30:0] ARRIVE_RST = 31'd6554;
  localparam logic [30:0] GOALR_RST  = 31'd26214;

  typedef enum logic [2:0] {
    MODE_ROUTE     = 3'd0,
    MODE_GOAL      = 3'd1,
    MODE_POSE      = 3'd2,
    MODE_CLR_ROUTE = 3'd3,
    MODE_CLR_GOAL  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CFG_CRUISE = 3'd0,
    CFG_HGAIN  = 3'd1,
    CFG_CGAIN  = 3'd2,
    CFG_RLIM   = 3'd3,
    CFG_ARRIVE = 3'd4,
    CFG_GOALR  = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_QMUL, ST_QCHK, ST_QWAIT,
    ST_RWAIT, ST_RLOAD, ST_C1, ST_C1W, ST_M1, ST_C2, ST_C2W, ST_M2, ST_DIST,
    ST_YMUL, ST_CMUL, ST_CDONE,
    ST_GCHK, ST_C3, ST_C3W, ST_M3, ST_C4, ST_C4W, ST_M4, ST_GDIST,
    ST_EMIT, ST_EMIT_G0, ST_EMIT_G1
  } st_e;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [IT_W-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      4'd0:    r = 20'sd51472;
      4'd1:    r = 20'sd30386;
      4'd2:    r = 20'sd16055;
      4'd3:    r = 20'sd8150;
      4'd4:    r = 20'sd4091;
      4'd5:    r = 20'sd2047;
      4'd6:    r = 20'sd1024;
      4'd7:    r = 20'sd512;
      4'd8:    r = 20'sd256;
      4'd9:    r = 20'sd128;
      4'd10:   r = 20'sd64;
      4'd11:   r = 20'sd32;
      4'd12:   r = 20'sd16;
      4'd13:   r = 20'sd8;
      4'd14:   r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_rate(input logic signed [PW-1:0] p,
                                                    input logic [14:0] lim);
    logic signed [PW-1:0] v;
    logic signed [PW-1:0] l;
    logic signed [15:0]   r;
    v = p >>> 13;
    l = signed'({{(PW-15){1'b0}}, lim});
    if (v > l) r = signed'({1'b0, lim});
    else if (v < -l) r = -signed'({1'b0, lim});
    else r = v[15:0];
    return r;
  endfunction

endpackage

[rtl/wgc_ram.sv]
module wgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/wgc_cordic.sv]
module wgc_cordic import wgc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  output logic                 done_o,
  output logic signed [CW-1:0] mag_o,
  output logic signed [ZW-1:0] ang_o
);

  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [IT_W-1:0]      it_q, it_d;
  logic                 run_q, run_d, done_q, done_d;
  logic signed [CW-1:0] sx, sy;
  logic signed [ZW-1:0] at;

  assign sx = x_q >>> it_q;
  assign sy = y_q >>> it_q;
  assign at = atan_entry(it_q);

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    it_d   = it_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      it_d = '0;
      if (x_i == '0 && y_i == '0) begin
        x_d    = '0;
        y_d    = '0;
        z_d    = '0;
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (x_i < 0) begin
        run_d = 1'b1;
        if (y_i >= 0) begin
          x_d = y_i;
          y_d = -x_i;
          z_d = HALF_PI_Q16;
        end else begin
          x_d = -y_i;
          y_d = x_i;
          z_d = -HALF_PI_Q16;
        end
      end else begin
        run_d = 1'b1;
        x_d   = x_i;
        y_d   = y_i;
        z_d   = '0;
      end
    end else if (run_q) begin
      if (!y_q[CW-1]) begin
        x_d = x_q + sy;
        y_d = y_q - sx;
        z_d = z_q + at;
      end else begin
        x_d = x_q - sy;
        y_d = y_q + sx;
        z_d = z_q - at;
      end
      it_d = it_q + IT_W'(1);
      if (it_q == IT_W'(CORD_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign mag_o  = x_q;
  assign ang_o  = z_q;

endmodule

[rtl/waypoint_guidance_controller.sv]
// Waypoint guidance controller. An item is taken when start_i is high and busy_o is low; busy_o
// stays high until the item is finished. A pose update is eight quaternion products through the
// shared multiplier, then, unless the attitude is degenerate, one 16-step CORDIC run. A final
// route write with a live route runs a control step: two CORDIC runs, plus gain scaling while
// the waypoint is not reached, and two more CORDIC runs when a destination is checked, all on
// the single shared CORDIC unit. Each result is shown for exactly one cycle with result_valid_o
// high; the receiver cannot stall, so it must take every word when the strobe is high. A
// destination hit gives two words on consecutive cycles, the second with last_o high.
module waypoint_guidance_controller import wgc_pkg::*; #(
  parameter int ROUTE_DEPTH = ROUTE_DEPTH_DEF,
  parameter int GOAL_DEPTH  = GOAL_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         slot_i,
  input  logic               final_entry_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [15:0] forward_cmd_o,
  output logic signed [15:0] yaw_rate_cmd_o,
  output logic signed [15:0] climb_cmd_o,
  output logic               waypoint_hit_o,
  output logic               goal_hit_o,
  output logic               last_o
);

  localparam int RAW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int GAW = (GOAL_DEPTH > 1) ? $clog2(GOAL_DEPTH) : 1;
  localparam int RLW = $clog2(ROUTE_DEPTH + 1);
  localparam int GLW = $clog2(GOAL_DEPTH + 1);

  st_e state_q, state_d;

  logic [14:0] cruise_q, rlim_q;
  logic [15:0] hgain_q, cgain_q;
  logic [30:0] arrive_q, goalr_q;

  logic [RLW-1:0] route_len_q, wp_idx_q;
  logic [GLW-1:0] goal_cnt_q, goal_idx_q;
  logic signed [31:0] pose_x_q, pose_y_q, pose_z_q;
  logic signed [15:0] yaw_q;

  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic [3:0]         cnt_q;
  logic signed [QW-1:0] acc_a_q, acc_b_q, acc_s_q, acc_d_q, s_abs;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [ZW-1:0] hd_q, pitch_q;
  logic signed [17:0] diff_raw, diff_wrap, diff_q;
  logic signed [15:0] fwd_q, yr_q, cl_q;
  logic               wh_q;

  logic signed [CW-1:0]  mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  mul_q;
  logic [CW-1:0]         scaled;

  logic                 cord_start, cord_done;
  logic signed [CW-1:0] cord_x, cord_y, cord_mag;
  logic signed [ZW-1:0] cord_ang;

  logic        accept, route_slot_ok, goal_slot_ok, route_live, goal_live, degenerate;
  logic [95:0] rt_rdata, gl_rdata;
  logic signed [31:0] rd_x, rd_y, rd_z;

  assign accept        = start_i && !busy_o;
  assign cfg_ready_o   = 1'b1;
  assign route_slot_ok = {24'd0, slot_i} < 32'(ROUTE_DEPTH);
  assign goal_slot_ok  = {24'd0, slot_i} < 32'(GOAL_DEPTH);
  assign route_live    = (route_len_q != '0) && (wp_idx_q < route_len_q);
  assign goal_live     = goal_idx_q < goal_cnt_q;
  assign scaled        = mul_q[CW+15:16];
  assign s_abs         = acc_s_q[QW-1] ? -acc_s_q : acc_s_q;
  assign degenerate    = (acc_d_q == '0) || (s_abs >= acc_d_q);
  assign diff_raw      = 18'(hd_q >>> 3) - 18'(yaw_q);

  always_comb begin
    if (diff_raw > PI_Q13) diff_wrap = diff_raw - TWO_PI_Q13;
    else if (diff_raw < -PI_Q13) diff_wrap = diff_raw + TWO_PI_Q13;
    else diff_wrap = diff_raw;
  end

  wgc_ram #(.WIDTH(96), .DEPTH(ROUTE_DEPTH)) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (accept && mode_i == MODE_ROUTE && route_slot_ok),
    .waddr_i (RAW'(slot_i)),
    .wdata_i ({pos_z_i, pos_y_i, pos_x_i}),
    .raddr_i (RAW'(wp_idx_q)),
    .rdata_o (rt_rdata)
  );

  wgc_ram #(.WIDTH(96), .DEPTH(GOAL_DEPTH)) u_goal_ram (
    .clk_i   (clk_i),
    .we_i    (accept && mode_i == MODE_GOAL && goal_slot_ok),
    .waddr_i (GAW'(slot_i)),
    .wdata_i ({pos_z_i, pos_y_i, pos_x_i}),
    .raddr_i (GAW'(goal_idx_q)),
    .rdata_o (gl_rdata)
  );

  assign rd_x = (state_q == ST_GCHK) ? gl_rdata[31:0]  : rt_rdata[31:0];
  assign rd_y = (state_q == ST_GCHK) ? gl_rdata[63:32] : rt_rdata[63:32];
  assign rd_z = (state_q == ST_GCHK) ? gl_rdata[95:64] : rt_rdata[95:64];

  wgc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x_i     (cord_x),
    .y_i     (cord_y),
    .done_o  (cord_done),
    .mag_o   (cord_mag),
    .ang_o   (cord_ang)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == MODE_ROUTE && final_entry_i) state_d = ST_RWAIT;
        else if (accept && mode_i == MODE_POSE) state_d = ST_QMUL;
      end
      ST_QMUL:    if (cnt_q == 4'd8) state_d = ST_QCHK;
      ST_QCHK:    state_d = degenerate ? ST_IDLE : ST_QWAIT;
      ST_QWAIT:   if (cord_done) state_d = ST_IDLE;
      ST_RWAIT:   state_d = route_live ? ST_RLOAD : ST_IDLE;
      ST_RLOAD:   state_d = ST_C1;
      ST_C1:      state_d = ST_C1W;
      ST_C1W:     if (cord_done) state_d = ST_M1;
      ST_M1:      state_d = ST_C2;
      ST_C2:      state_d = ST_C2W;
      ST_C2W:     if (cord_done) state_d = ST_M2;
      ST_M2:      state_d = ST_DIST;
      ST_DIST:    state_d = (scaled > CW'(arrive_q)) ? ST_YMUL : ST_GCHK;
      ST_YMUL:    state_d = ST_CMUL;
      ST_CMUL:    state_d = ST_CDONE;
      ST_CDONE:   state_d = ST_GCHK;
      ST_GCHK:    state_d = goal_live ? ST_C3 : ST_EMIT;
      ST_C3:      state_d = ST_C3W;
      ST_C3W:     if (cord_done) state_d = ST_M3;
      ST_M3:      state_d = ST_C4;
      ST_C4:      state_d = ST_C4W;
      ST_C4W:     if (cord_done) state_d = ST_M4;
      ST_M4:      state_d = ST_GDIST;
      ST_GDIST:   state_d = (scaled < CW'(goalr_q)) ? ST_EMIT_G0 : ST_EMIT;
      ST_EMIT_G0: state_d = ST_EMIT_G1;
      ST_EMIT_G1: state_d = ST_IDLE;
      ST_EMIT:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // unit controls and ports
  always_comb begin
    cord_start = 1'b0;
    cord_x     = CW'(dx_q);
    cord_y     = CW'(dy_q);
    mul_a      = cord_mag;
    mul_b      = KINV_Q16;
    unique case (state_q)
      ST_QMUL: begin
        unique case (cnt_q)
          4'd0:    begin mul_a = CW'(qx_q); mul_b = MBW'(qy_q); end
          4'd1:    begin mul_a = CW'(qw_q); mul_b = MBW'(qz_q); end
          4'd2:    begin mul_a = CW'(qw_q); mul_b = MBW'(qw_q); end
          4'd3:    begin mul_a = CW'(qx_q); mul_b = MBW'(qx_q); end
          4'd4:    begin mul_a = CW'(qy_q); mul_b = MBW'(qy_q); end
          4'd5:    begin mul_a = CW'(qz_q); mul_b = MBW'(qz_q); end
          4'd6:    begin mul_a = CW'(qx_q); mul_b = MBW'(qz_q); end
          default: begin mul_a = CW'(qw_q); mul_b = MBW'(qy_q); end
        endcase
      end
      ST_QCHK: begin
        cord_start = !degenerate;
        cord_x     = CW'(acc_b_q);
        cord_y     = CW'(acc_a_q);
      end
      ST_C1, ST_C3: cord_start = 1'b1;
      ST_C2, ST_C4: begin
        cord_start = 1'b1;
        cord_x     = signed'(scaled);
        cord_y     = CW'(dz_q);
      end
      ST_YMUL: begin
        mul_a = CW'(diff_q);
        mul_b = signed'({2'b00, hgain_q});
      end
      ST_CMUL: begin
        mul_a = CW'(pitch_q >>> 3);
        mul_b = signed'({2'b00, cgain_q});
      end
      default: ;
    endcase

    busy_o         = state_q != ST_IDLE;
    result_valid_o = (state_q == ST_EMIT) || (state_q == ST_EMIT_G0) || (state_q == ST_EMIT_G1);
    forward_cmd_o  = (state_q == ST_EMIT) ? fwd_q : '0;
    yaw_rate_cmd_o = (state_q == ST_EMIT) ? yr_q : '0;
    climb_cmd_o    = (state_q == ST_EMIT) ? cl_q : '0;
    waypoint_hit_o = result_valid_o && wh_q;
    goal_hit_o     = (state_q == ST_EMIT_G0) || (state_q == ST_EMIT_G1);
    last_o         = (state_q == ST_EMIT) || (state_q == ST_EMIT_G1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cruise_q    <= CRUISE_RST;
      hgain_q     <= HGAIN_RST;
      cgain_q     <= CGAIN_RST;
      rlim_q      <= RLIM_RST;
      arrive_q    <= ARRIVE_RST;
      goalr_q     <= GOALR_RST;
      route_len_q <= '0;
      goal_cnt_q  <= '0;
      wp_idx_q    <= '0;
      goal_idx_q  <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_z_q    <= '0;
      yaw_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_CRUISE: cruise_q <= cfg_data_i[14:0];
          CFG_HGAIN:  hgain_q  <= cfg_data_i[15:0];
          CFG_CGAIN:  cgain_q  <= cfg_data_i[15:0];
          CFG_RLIM:   rlim_q   <= cfg_data_i[14:0];
          CFG_ARRIVE: arrive_q <= cfg_data_i[30:0];
          CFG_GOALR:  goalr_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (accept) begin
        cnt_q <= '0;
        unique case (mode_i)
          MODE_ROUTE: begin
            if (final_entry_i) begin
              route_len_q <= route_slot_ok ? RLW'(slot_i) + RLW'(1) : RLW'(ROUTE_DEPTH);
            end
          end
          MODE_GOAL: begin
            if (final_entry_i) begin
              goal_cnt_q <= goal_slot_ok ? GLW'(slot_i) + GLW'(1) : GLW'(GOAL_DEPTH);
            end
          end
          MODE_POSE: begin
            pose_x_q <= pos_x_i;
            pose_y_q <= pos_y_i;
            pose_z_q <= pos_z_i;
          end
          MODE_CLR_ROUTE: route_len_q <= '0;
          MODE_CLR_GOAL:  goal_cnt_q  <= '0;
          default: ;
        endcase
      end
      if (state_q == ST_QMUL) cnt_q <= cnt_q + 4'd1;
      if (state_q == ST_QCHK && degenerate) yaw_q <= '0;
      if (state_q == ST_QWAIT && cord_done) yaw_q <= 16'(cord_ang >>> 3);
      if (state_q == ST_DIST && !(scaled > CW'(arrive_q))) wp_idx_q <= wp_idx_q + RLW'(1);
      if (state_q == ST_GDIST && scaled < CW'(goalr_q)) begin
        goal_idx_q <= (goal_idx_q + GLW'(1) == goal_cnt_q) ? '0 : goal_idx_q + GLW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (accept) begin
      qx_q    <= quat_x_i;
      qy_q    <= quat_y_i;
      qz_q    <= quat_z_i;
      qw_q    <= quat_w_i;
      acc_a_q <= '0;
      acc_b_q <= '0;
      acc_s_q <= '0;
      acc_d_q <= '0;
    end
    // accumulate the product issued in the previous cycle
    if (state_q == ST_QMUL && cnt_q != 4'd0) begin
      unique case (cnt_q)
        4'd1, 4'd2: acc_a_q <= acc_a_q + (QW'(mul_q) <<< 1);
        4'd3, 4'd4: begin
          acc_b_q <= acc_b_q + QW'(mul_q);
          acc_d_q <= acc_d_q + QW'(mul_q);
        end
        4'd5, 4'd6: begin
          acc_b_q <= acc_b_q - QW'(mul_q);
          acc_d_q <= acc_d_q + QW'(mul_q);
        end
        4'd7:    acc_s_q <= acc_s_q + (QW'(mul_q) <<< 1);
        default: acc_s_q <= acc_s_q - (QW'(mul_q) <<< 1);
      endcase
    end
    if (state_q == ST_RLOAD || (state_q == ST_GCHK && goal_live)) begin
      dx_q <= 33'(rd_x) - 33'(pose_x_q);
      dy_q <= 33'(rd_y) - 33'(pose_y_q);
      dz_q <= 33'(rd_z) - 33'(pose_z_q);
    end
    if (state_q == ST_M1) hd_q <= cord_ang;
    if (state_q == ST_M2) pitch_q <= cord_ang;
    if (state_q == ST_DIST) begin
      if (scaled > CW'(arrive_q)) begin
        diff_q <= diff_wrap;
        fwd_q  <= signed'({1'b0, cruise_q});
        wh_q   <= 1'b0;
      end else begin
        fwd_q <= '0;
        yr_q  <= '0;
        cl_q  <= '0;
        wh_q  <= 1'b1;
      end
    end
    if (state_q == ST_CMUL) yr_q <= clamp_rate(mul_q, rlim_q);
    if (state_q == ST_CDONE) cl_q <= clamp_rate(mul_q, rlim_q);
  end

endmodule

[rtl/wgc_checker.sv]
`include "waypoint_guidance_controller_macros.svh"

module wgc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [2:0]  mode_i,
  input logic [7:0]  slot_i,
  input logic        final_entry_i,
  input logic [31:0] pos_x_i,
  input logic [31:0] pos_y_i,
  input logic [31:0] pos_z_i,
  input logic [15:0] quat_x_i,
  input logic [15:0] quat_y_i,
  input logic [15:0] quat_z_i,
  input logic [15:0] quat_w_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [31:0] cfg_data_i,
  input logic        result_valid_o,
  input logic [15:0] forward_cmd_o,
  input logic [15:0] yaw_rate_cmd_o,
  input logic [15:0] climb_cmd_o,
  input logic        waypoint_hit_o,
  input logic        goal_hit_o,
  input logic        last_o
);

  `WGC_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> (!busy_o && !result_valid_o), "active in reset")
  `WGC_ASSERT(a_word_while_busy, result_valid_o |-> busy_o, "word outside a busy period")
  `WGC_ASSERT(a_goal_pair, (result_valid_o && !last_o) |=> (result_valid_o && last_o && goal_hit_o), "goal pair broken")
  `WGC_ASSERT(a_hit_zero_cmd, (result_valid_o && (waypoint_hit_o || goal_hit_o)) |-> (forward_cmd_o == 16'd0 && yaw_rate_cmd_o == 16'd0 && climb_cmd_o == 16'd0), "hit with nonzero command")
  `WGC_ASSERT(a_table_write_quick, (start_i && !busy_o && mode_i == 3'd1) |=> (!busy_o && !result_valid_o), "destination write not single cycle")

endmodule

bind waypoint_guidance_controller wgc_checker u_wgc_checker (.*);

[verif/tb_waypoint_guidance_controller.sv]
module tb_waypoint_guidance_controller;
  import wgc_pkg::*;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         slot;
    logic               fin;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } cmd_t;

  typedef struct packed {
    logic [15:0] fwd;
    logic [15:0] yaw;
    logic [15:0] clb;
    logic        wh;
    logic        gh;
    logic        lst;
  } steer_t;

  localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         mode_i = '0;
  logic [7:0]         slot_i = '0;
  logic               final_entry_i = 1'b0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic signed [15:0] quat_w_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               result_valid_o;
  logic signed [15:0] forward_cmd_o;
  logic signed [15:0] yaw_rate_cmd_o;
  logic signed [15:0] climb_cmd_o;
  logic               waypoint_hit_o;
  logic               goal_hit_o;
  logic               last_o;

  waypoint_guidance_controller dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // guidance state, copy 0 follows generation, copy 1 follows accepted items
  int          rx [2][256];
  int          ry [2][256];
  int          rz [2][256];
  int          gx [2][16];
  int          gy [2][16];
  int          gz [2][16];
  int unsigned rlen [2];
  int unsigned gcnt [2];
  int unsigned widx [2];
  int unsigned gidx [2];
  int          ppx [2];
  int          ppy [2];
  int          ppz [2];
  longint      pyaw [2];
  longint      cfgv [2][6];
  bit          route_w [256];
  bit          goal_w [16];

  cmd_t   pending_q[$];
  steer_t steer_q[$];
  int     errors, n_items, n_words, n_wp, n_goal;
  int     quota;

  function automatic void init_guide(int k);
    for (int i = 0; i < 256; i++) begin
      rx[k][i] = 0; ry[k][i] = 0; rz[k][i] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      gx[k][i] = 0; gy[k][i] = 0; gz[k][i] = 0;
    end
    rlen[k] = 0; gcnt[k] = 0; widx[k] = 0; gidx[k] = 0;
    ppx[k] = 0; ppy[k] = 0; ppz[k] = 0; pyaw[k] = 0;
    cfgv[k][CFG_CRUISE] = CRUISE_RST;
    cfgv[k][CFG_HGAIN]  = HGAIN_RST;
    cfgv[k][CFG_CGAIN]  = CGAIN_RST;
    cfgv[k][CFG_RLIM]   = RLIM_RST;
    cfgv[k][CFG_ARRIVE] = ARRIVE_RST;
    cfgv[k][CFG_GOALR]  = GOALR_RST;
  endfunction

  function automatic void apply_cfg(int k, logic [2:0] idx, logic [31:0] data);
    case (idx)
      CFG_CRUISE: cfgv[k][CFG_CRUISE] = data[14:0];
      CFG_HGAIN:  cfgv[k][CFG_HGAIN]  = data[15:0];
      CFG_CGAIN:  cfgv[k][CFG_CGAIN]  = data[15:0];
      CFG_RLIM:   cfgv[k][CFG_RLIM]   = data[14:0];
      CFG_ARRIVE: cfgv[k][CFG_ARRIVE] = data[30:0];
      CFG_GOALR:  cfgv[k][CFG_GOALR]  = data[30:0];
      default: ;
    endcase
  endfunction

  function automatic void vec_cordic(longint xi, longint yi, output longint mag,
                                     output longint ang);
    longint x, y, z, t, dx, dy;
    longint unsigned p;
    x = xi; y = yi; z = 0;
    if (x == 0 && y == 0) begin
      mag = 0; ang = 0;
      return;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q16;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q16;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += ATAN_Q16[i];
      end else begin
        x -= dy; y += dx; z -= ATAN_Q16[i];
      end
    end
    p = longint'(unsigned'(x)) * 64'd39797;
    mag = longint'(p >> 16);
    ang = z;
  endfunction

  function automatic longint rate_clamp(int k, longint gain, longint ang);
    longint v, lim;
    v = (gain * ang) >>> 13;
    lim = cfgv[k][CFG_RLIM];
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic int steer_step(int k, output steer_t o0, output steer_t o1);
    longint dx, dy, dz, h, hd, rng, pitch, diff, fwd, yr, cl, gh, gd, dum;
    int unsigned w, g;
    bit wh;
    o0 = '0; o1 = '0; fwd = 0; yr = 0; cl = 0; wh = 0;
    w = widx[k];
    if (rlen[k] == 0 || w >= rlen[k] || w >= 256) return 0;
    dx = longint'(rx[k][w]) - ppx[k];
    dy = longint'(ry[k][w]) - ppy[k];
    dz = longint'(rz[k][w]) - ppz[k];
    vec_cordic(dx, dy, h, hd);
    vec_cordic(h, dz, rng, pitch);
    if (rng > cfgv[k][CFG_ARRIVE]) begin
      diff = (hd >>> 3) - pyaw[k];
      while (diff > PI_Q13) diff -= TWO_PI_Q13;
      while (diff < -PI_Q13) diff += TWO_PI_Q13;
      fwd = cfgv[k][CFG_CRUISE];
      yr = rate_clamp(k, cfgv[k][CFG_HGAIN], diff);
      cl = rate_clamp(k, cfgv[k][CFG_CGAIN], pitch >>> 3);
    end else begin
      wh = 1;
      widx[k] = w + 1;
    end
    if (gidx[k] < gcnt[k] && gidx[k] < 16) begin
      g = gidx[k];
      dx = longint'(gx[k][g]) - ppx[k];
      dy = longint'(gy[k][g]) - ppy[k];
      dz = longint'(gz[k][g]) - ppz[k];
      vec_cordic(dx, dy, gh, dum);
      vec_cordic(gh, dz, gd, dum);
      if (gd < cfgv[k][CFG_GOALR]) begin
        o0 = '{fwd: '0, yaw: '0, clb: '0, wh: wh, gh: 1'b1, lst: 1'b0};
        o1 = '{fwd: '0, yaw: '0, clb: '0, wh: wh, gh: 1'b1, lst: 1'b1};
        gidx[k] = (g + 1) % gcnt[k];
        return 2;
      end
    end
    o0 = '{fwd: fwd[15:0], yaw: yr[15:0], clb: cl[15:0], wh: wh, gh: 1'b0, lst: 1'b1};
    return 1;
  endfunction

  function automatic longint quat_heading(longint qx, longint qy, longint qz, longint qw);
    longint a, b, s, d, mag, ang;
    a = 2 * (qx * qy + qw * qz);
    b = qw * qw + qx * qx - qy * qy - qz * qz;
    s = 2 * (qx * qz - qw * qy);
    d = qw * qw + qx * qx + qy * qy + qz * qz;
    if (s < 0) s = -s;
    if (d == 0 || s >= d) return 0;
    vec_cordic(b, a, mag, ang);
    return ang >>> 3;
  endfunction

  function automatic int guidance_step(int k, cmd_t c, output steer_t o0, output steer_t o1);
    o0 = '0; o1 = '0;
    case (c.mode)
      MODE_ROUTE: begin
        rx[k][c.slot] = c.px; ry[k][c.slot] = c.py; rz[k][c.slot] = c.pz;
        if (!c.fin) return 0;
        rlen[k] = c.slot + 1;
        return steer_step(k, o0, o1);
      end
      MODE_GOAL: begin
        if (c.slot < 16) begin
          gx[k][c.slot] = c.px; gy[k][c.slot] = c.py; gz[k][c.slot] = c.pz;
        end
        if (c.fin) gcnt[k] = (c.slot < 16) ? c.slot + 1 : 16;
      end
      MODE_POSE: begin
        ppx[k] = c.px; ppy[k] = c.py; ppz[k] = c.pz;
        pyaw[k] = quat_heading(c.qx, c.qy, c.qz, c.qw);
      end
      MODE_CLR_ROUTE: rlen[k] = 0;
      MODE_CLR_GOAL:  gcnt[k] = 0;
      default: ;
    endcase
    return 0;
  endfunction

  // driver
  cmd_t   drv_cmd;
  steer_t acc0, acc1;
  int     gap_left, acc_n;
  bit     burst;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      gap_left <= 0;
      burst    <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        acc_n = guidance_step(1, drv_cmd, acc0, acc1);
        if (acc_n > 0) steer_q.push_back(acc0);
        if (acc_n > 1) steer_q.push_back(acc1);
        n_items++;
      end
      if (start_i && busy_o) begin
      end else if (gap_left != 0) begin
        start_i  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        drv_cmd = pending_q.pop_front();
        mode_i        <= drv_cmd.mode;
        slot_i        <= drv_cmd.slot;
        final_entry_i <= drv_cmd.fin;
        pos_x_i       <= drv_cmd.px;
        pos_y_i       <= drv_cmd.py;
        pos_z_i       <= drv_cmd.pz;
        quat_x_i      <= drv_cmd.qx;
        quat_y_i      <= drv_cmd.qy;
        quat_z_i      <= drv_cmd.qz;
        quat_w_i      <= drv_cmd.qw;
        start_i       <= 1'b1;
        if ($urandom_range(0, 19) == 0) burst <= !burst;
        gap_left <= burst ? 0 : $urandom_range(0, 11);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && cfg_valid_i && cfg_ready_o) apply_cfg(1, cfg_index_i, cfg_data_i);

  task automatic check_field(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
    end
  endtask

  // monitor
  steer_t mon_exp;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      n_words++;
      if (waypoint_hit_o) n_wp++;
      if (goal_hit_o) n_goal++;
      if (steer_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got fwd %0h yaw %0h climb %0h",
                 $time, forward_cmd_o, yaw_rate_cmd_o, climb_cmd_o);
      end else begin
        mon_exp = steer_q.pop_front();
        check_field("forward_cmd", mon_exp.fwd, forward_cmd_o);
        check_field("yaw_rate_cmd", mon_exp.yaw, yaw_rate_cmd_o);
        check_field("climb_cmd", mon_exp.clb, climb_cmd_o);
        check_field("waypoint_hit", mon_exp.wh, waypoint_hit_o);
        check_field("goal_hit", mon_exp.gh, goal_hit_o);
        check_field("last", mon_exp.lst, last_o);
      end
    end
  end

  // stimulus generation
  function automatic int route_prefix();
    int i;
    i = 0;
    while (i < 256 && route_w[i]) i++;
    return i;
  endfunction

  function automatic int goal_prefix();
    int i;
    i = 0;
    while (i < 16 && goal_w[i]) i++;
    return i;
  endfunction

  function automatic cmd_t blank(logic [2:0] m);
    cmd_t c;
    c.mode = m; c.slot = $urandom; c.fin = 1'b0;
    c.px = $urandom; c.py = $urandom; c.pz = $urandom;
    c.qx = $urandom; c.qy = $urandom; c.qz = $urandom; c.qw = $urandom;
    return c;
  endfunction

  function automatic int near();
    return int'($urandom_range(0, 4194304)) - 2097152;
  endfunction

  function automatic int jitter();
    return $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 8192)) - 4096;
  endfunction

  task automatic add_cmd(cmd_t c);
    steer_t d0, d1;
    int n;
    n = guidance_step(0, c, d0, d1);
    if (c.mode == MODE_ROUTE) route_w[c.slot] = 1;
    if (c.mode == MODE_GOAL && c.slot < 16) goal_w[c.slot] = 1;
    pending_q.push_back(c);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || start_i || steer_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] v);
    logic [31:0] d;
    d = v;
    if ($urandom_range(0, 1)) d[31] = 1'b1;
    apply_cfg(0, idx, d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic noise();
    cmd_t c;
    case ($urandom_range(0, 5))
      0: c = blank(3'($urandom_range(5, 7)));
      1: c = blank(MODE_ROUTE);
      2: begin
        c = blank(MODE_GOAL);
        if (goal_prefix() == 16) c.fin = $urandom_range(0, 1);
      end
      3: c = blank(MODE_POSE);
      4: c = blank(MODE_CLR_ROUTE);
      default: c = blank(MODE_CLR_GOAL);
    endcase
    add_cmd(c);
  endtask

  task automatic episode();
    cmd_t c;
    int pre, gp, s, w, k;
    if ($urandom_range(0, 99) < 12) begin
      noise();
      return;
    end
    pre = route_prefix();
    if (pre < 256 && (pre <= widx[0] || $urandom_range(0, 2) == 0)) begin
      k = $urandom_range(1, 3);
      repeat (k) if (route_prefix() < 256) begin
        c = blank(MODE_ROUTE);
        c.slot = route_prefix();
        c.px = near(); c.py = near(); c.pz = near();
        add_cmd(c);
      end
    end
    gp = goal_prefix();
    if ($urandom_range(0, 5) == 0) begin
      c = blank(MODE_GOAL);
      c.slot = $urandom_range(0, (gp < 16) ? gp : 15);
      c.fin = $urandom_range(0, 1);
      c.px = near(); c.py = near(); c.pz = near();
      add_cmd(c);
    end
    c = blank(MODE_POSE);
    w = widx[0];
    pre = route_prefix();
    k = $urandom_range(0, 9);
    if (k < 3 && w < pre) begin
      c.px = rx[0][w] + jitter(); c.py = ry[0][w] + jitter(); c.pz = rz[0][w] + jitter();
    end else if (k < 5 && gidx[0] < gcnt[0]) begin
      c.px = gx[0][gidx[0]] + jitter(); c.py = gy[0][gidx[0]] + jitter();
      c.pz = gz[0][gidx[0]] + jitter();
    end else begin
      c.px = near(); c.py = near(); c.pz = near();
    end
    if ($urandom_range(0, 9) == 0) begin
      c.qx = 0; c.qy = 0; c.qz = 0; c.qw = 16'sd32767;
    end
    add_cmd(c);
    w = widx[0];
    if (w < pre) begin
      s = $urandom_range(w, pre - 1);
      c = blank(MODE_ROUTE);
      c.slot = s;
      c.fin = 1'b1;
      if (s != w && $urandom_range(0, 4) == 0) begin
        c.px = near(); c.py = near(); c.pz = near();
      end else begin
        c.px = rx[0][s]; c.py = ry[0][s]; c.pz = rz[0][s];
      end
      add_cmd(c);
    end
  endtask

  function automatic cmd_t mk(logic [2:0] m, logic [7:0] sl, logic f, int x, int y, int z,
                              int qx, int qy, int qz, int qw);
    cmd_t c;
    c = '{mode: m, slot: sl, fin: f, px: x, py: y, pz: z,
          qx: 16'(qx), qy: 16'(qy), qz: 16'(qz), qw: 16'(qw)};
    return c;
  endfunction

  localparam int M10 = 10 << 16;
  localparam int M5  = 5 << 16;
  localparam int M2  = 2 << 16;
  localparam int PMAX = 32'h7fffffff;
  localparam int PMIN = 32'h80000000;

  longint phase_cfg [5][6] = '{
    '{614, 1843, 205, 1024, 6554, 26214},
    '{32767, 65535, 65535, 32767, 0, 0},
    '{0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff},
    '{-1, -1, -1, -1, -1, -1},
    '{3000, 65535, 40000, 300, 60000, 200000}
  };
  int phase_len [5] = '{300, 300, 80, 350, 350};

  initial begin
    rst_ni <= 1'b0;
    init_guide(0);
    init_guide(1);
    errors = 0; n_items = 0; n_words = 0; n_wp = 0; n_goal = 0;
    quota = 25;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_cmd(mk(MODE_POSE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(MODE_ROUTE, 0, 1, 0, 0, 0, 1, 2, 3, 4));
    add_cmd(mk(MODE_ROUTE, 1, 0, M10, M5, M2, 0, 0, 0, 0));
    add_cmd(mk(MODE_ROUTE, 1, 1, M10, M5, M2, 0, 0, 0, 0));
    add_cmd(mk(MODE_POSE, 0, 0, PMAX, PMAX, PMAX, 32767, -32768, 32767, -32768));
    add_cmd(mk(MODE_ROUTE, 2, 1, PMIN, PMIN, PMIN, -1, -1, -1, -1));
    add_cmd(mk(MODE_GOAL, 0, 1, M10, M5, M2, 0, 0, 0, 0));
    add_cmd(mk(MODE_POSE, 0, 0, M10, M5, M2, 0, 0, 16384, 16384));
    add_cmd(mk(MODE_ROUTE, 2, 1, PMIN, PMIN, PMIN, 0, 0, 0, 0));
    add_cmd(mk(MODE_POSE, 0, 0, -M10, M5, -M2, 0, 16384, 0, 16384));
    add_cmd(mk(MODE_ROUTE, 2, 1, PMIN, PMIN, PMIN, 0, 0, 0, 0));
    add_cmd(mk(3'd5, 8'hff, 1, PMAX, PMIN, -1, -1, -1, -1, -1));
    add_cmd(mk(3'd6, 8'h55, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(3'd7, 8'haa, 1, 1, 1, 1, 1, 1, 1, 1));
    add_cmd(mk(MODE_GOAL, 31, 0, PMAX, PMAX, PMAX, 0, 0, 0, 0));
    add_cmd(mk(MODE_GOAL, 200, 0, PMIN, PMIN, PMIN, 0, 0, 0, 0));
    add_cmd(mk(MODE_CLR_GOAL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(MODE_CLR_ROUTE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(MODE_ROUTE, 255, 0, -M10, -M10, -M10, 0, 0, 0, 0));
    add_cmd(mk(MODE_ROUTE, 1, 1, M10, M5, M2, 0, 0, 0, 0));
    add_cmd(mk(MODE_ROUTE, 2, 1, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(MODE_POSE, 0, 0, -PMAX, PMAX, 0, -32768, -32768, -32768, -32768));
    add_cmd(mk(MODE_ROUTE, 2, 1, M2, -M5, M10, 0, 0, 0, 0));

    for (int p = 0; p < 5; p++) begin
      drain();
      repeat (120) @(posedge clk_i);
      if (p == 3) begin
        cfg_write(CFG_CRUISE, $urandom_range(0, 32767));
        cfg_write(CFG_HGAIN, $urandom_range(0, 65535));
        cfg_write(CFG_CGAIN, $urandom_range(0, 65535));
        cfg_write(CFG_RLIM, $urandom_range(0, 4096));
        cfg_write(CFG_ARRIVE, $urandom_range(0, 1 << 20));
        cfg_write(CFG_GOALR, $urandom_range(0, 1 << 22));
      end else begin
        cfg_write(CFG_CRUISE, phase_cfg[p][CFG_CRUISE]);
        cfg_write(CFG_HGAIN, phase_cfg[p][CFG_HGAIN]);
        cfg_write(CFG_CGAIN, phase_cfg[p][CFG_CGAIN]);
        cfg_write(CFG_RLIM, phase_cfg[p][CFG_RLIM]);
        cfg_write(CFG_ARRIVE, phase_cfg[p][CFG_ARRIVE]);
        cfg_write(CFG_GOALR, phase_cfg[p][CFG_GOALR]);
      end
      quota += phase_len[p];
      while (n_items + pending_q.size() < quota && n_items < 1800) begin
        episode();
        if ($urandom_range(0, 120) == 0) drain();
      end
    end

    drain();
    repeat (120) @(posedge clk_i);
    $display("covered %0d items over 5 register settings: %0d words, %0d waypoint hits, %0d goal hits",
             n_items, n_words, n_wp, n_goal);
    if (errors == 0) begin
      $display("tb_waypoint_guidance_controller: clean");
    end else begin
      $display("tb_waypoint_guidance_controller: errors");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout waiting for the block");
    $display("tb_waypoint_guidance_controller: errors");
    $finish;
  end

endmodule
